/* hdl/exub_pkg.sv */
// ----------------------------------------------------------------------------
// exub_pkg
// Shared types, constants and helpers of the execute unit.
// ----------------------------------------------------------------------------
package exub_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int WIDE_WIDTH = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [31:0] PC_STEP = 32'd4;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,  OP_SUB  = 5'd1,  OP_AND  = 5'd2,  OP_OR   = 5'd3,
        OP_XOR   = 5'd4,  OP_MOVC = 5'd5,  OP_ADDL = 5'd6,  OP_SUBL = 5'd7,
        OP_CMP   = 5'd8,  OP_CML  = 5'd9,  OP_MUL  = 5'd10, OP_DIV  = 5'd11,
        OP_BZ    = 5'd12, OP_BNZ  = 5'd13, OP_BP   = 5'd14, OP_BN   = 5'd15,
        OP_BNP   = 5'd16, OP_JUMP = 5'd17, OP_JALP = 5'd18, OP_RET  = 5'd19,
        OP_LOAD  = 5'd20, OP_STW  = 5'd21, OP_LDR  = 5'd22, OP_STR  = 5'd23,
        OP_NOP   = 5'd24, OP_HALT = 5'd25
    } t_op;

    typedef struct packed {
        logic fw;
        logic ctl;
        logic is_div;
    } t_cls;

    typedef struct packed {
        t_op         op;
        t_cls        cls;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] imm;
        logic [31:0] pc;
        logic [31:0] pred;
        logic        z;
        logic        p;
        logic        n;
    } t_qent;

    // sign-extend a 32-bit field to the data width
    function automatic logic [DATA_WIDTH-1:0] f_opnd(input logic [31:0] v);
        logic signed [WIDE_WIDTH-1:0] t;
        t = WIDE_WIDTH'(signed'(v));
        return t[DATA_WIDTH-1:0];
    endfunction

    // zero-extend a 32-bit pc value to the data width
    function automatic logic [DATA_WIDTH-1:0] f_pcval(input logic [31:0] v);
        logic [WIDE_WIDTH-1:0] t;
        t = WIDE_WIDTH'(v);
        return t[DATA_WIDTH-1:0];
    endfunction

    // sign-extend a data-width value into a 32-bit port
    function automatic logic [31:0] f_out(input logic [DATA_WIDTH-1:0] v);
        logic signed [WIDE_WIDTH-1:0] t;
        t = WIDE_WIDTH'(signed'(v));
        return t[31:0];
    endfunction

endpackage

/* hdl/execute_unit_with_branch_resolve_top.sv */
// ----------------------------------------------------------------------------
// execute_unit_with_branch_resolve_top
// Execute unit with ALU, multiply, divide and branch resolution.
//
// Input channel: drive the instruction fields and raise push; the item is
// taken at a clock edge where push is high and full is low.
// Result channel: while empty is low the oldest result is on the o_ ports;
// it is taken at a clock edge where pop is high and empty is low.
// Every item gives exactly one result, in order.
// Throughput: one item per cycle, sustained while the receiver pops results.
// Each item passes the queue, the execute pipeline stages and an output
// register; the divider resolves one quotient bit per pipeline stage, and all
// operations travel through the same stages to keep order.
// A two-entry queue parts the classifying front from the execute pipeline.
// When the receiver holds off pop, the pipeline holds and the queue fills;
// full then rises and holds off new items.
// Reset (synchronous, i_rst_n low) empties the queue and the pipeline.
// ----------------------------------------------------------------------------
module execute_unit_with_branch_resolve_top import exub_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [4:0]  i_operation,
    input  logic [31:0] i_src_a,
    input  logic [31:0] i_src_b,
    input  logic [31:0] i_src_c,
    input  logic [31:0] i_immediate,
    input  logic [31:0] i_inst_pc,
    input  logic [31:0] i_predicted_pc,
    input  logic        i_in_zero,
    input  logic        i_in_positive,
    input  logic        i_in_negative,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_result_value,
    output logic        o_out_zero,
    output logic        o_out_positive,
    output logic        o_out_negative,
    output logic        o_flags_written,
    output logic        o_branch_taken,
    output logic        o_redirect,
    output logic [31:0] o_correct_pc,
    output logic        o_divide_by_zero
);

    logic  take, avail;
    t_qent head;

    exub_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_operation    (i_operation),
        .i_src_a        (i_src_a),
        .i_src_b        (i_src_b),
        .i_src_c        (i_src_c),
        .i_immediate    (i_immediate),
        .i_inst_pc      (i_inst_pc),
        .i_predicted_pc (i_predicted_pc),
        .i_in_zero      (i_in_zero),
        .i_in_positive  (i_in_positive),
        .i_in_negative  (i_in_negative),
        .i_take         (take),
        .o_avail        (avail),
        .o_head         (head)
    );

    exub_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_avail          (avail),
        .i_head           (head),
        .o_take           (take),
        .empty            (empty),
        .pop              (pop),
        .o_result_value   (o_result_value),
        .o_out_zero       (o_out_zero),
        .o_out_positive   (o_out_positive),
        .o_out_negative   (o_out_negative),
        .o_flags_written  (o_flags_written),
        .o_branch_taken   (o_branch_taken),
        .o_redirect       (o_redirect),
        .o_correct_pc     (o_correct_pc),
        .o_divide_by_zero (o_divide_by_zero)
    );

endmodule

/* hdl/exub_front.sv */
// ----------------------------------------------------------------------------
// exub_front
// Accepts items, classifies the opcode and buffers them in a short queue.
// ----------------------------------------------------------------------------
module exub_front import exub_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [4:0]  i_operation,
    input  logic [31:0] i_src_a,
    input  logic [31:0] i_src_b,
    input  logic [31:0] i_src_c,
    input  logic [31:0] i_immediate,
    input  logic [31:0] i_inst_pc,
    input  logic [31:0] i_predicted_pc,
    input  logic        i_in_zero,
    input  logic        i_in_positive,
    input  logic        i_in_negative,
    input  logic        i_take,
    output logic        o_avail,
    output t_qent       o_head
);

    t_qent       r_mem [QUEUE_DEPTH];
    logic [$clog2(QUEUE_DEPTH)-1:0] r_wp, r_rp;
    logic [$clog2(QUEUE_DEPTH):0]   r_cnt;
    t_cls        n_cls;
    t_qent       n_ent;
    logic        wr, rd;

    always_comb begin
        n_cls = '0;
        unique case (t_op'(i_operation))
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_ADDL, OP_SUBL,
            OP_CMP, OP_CML, OP_MUL: n_cls.fw = 1'b1;
            OP_DIV: begin
                n_cls.fw = 1'b1;
                n_cls.is_div = 1'b1;
            end
            OP_BZ, OP_BNZ, OP_BP, OP_BN, OP_BNP, OP_JUMP, OP_JALP, OP_RET:
                n_cls.ctl = 1'b1;
            default: n_cls = '0;
        endcase
    end

    always_comb begin
        n_ent.op   = t_op'(i_operation);
        n_ent.cls  = n_cls;
        n_ent.a    = i_src_a;
        n_ent.b    = i_src_b;
        n_ent.c    = i_src_c;
        n_ent.imm  = i_immediate;
        n_ent.pc   = i_inst_pc;
        n_ent.pred = i_predicted_pc;
        n_ent.z    = i_in_zero;
        n_ent.p    = i_in_positive;
        n_ent.n    = i_in_negative;
    end

    assign full    = (r_cnt == ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign wr      = push && !full;
    assign rd      = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= n_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + ($clog2(QUEUE_DEPTH)+1)'(wr)
                           - ($clog2(QUEUE_DEPTH)+1)'(rd);
        end
    end

endmodule

/* hdl/exub_back.sv */
// ----------------------------------------------------------------------------
// exub_back
// Executes items: ALU, branch resolution and a one-bit-per-stage divider.
// ----------------------------------------------------------------------------
module exub_back import exub_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_avail,
    input  t_qent       i_head,
    output logic        o_take,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_result_value,
    output logic        o_out_zero,
    output logic        o_out_positive,
    output logic        o_out_negative,
    output logic        o_flags_written,
    output logic        o_branch_taken,
    output logic        o_redirect,
    output logic [31:0] o_correct_pc,
    output logic        o_divide_by_zero
);

    localparam int DW = DATA_WIDTH;

    typedef struct packed {
        logic          fw;
        logic          is_div;
        logic          dz;
        logic          qneg;
        logic [DW-1:0] res;
        logic          z;
        logic          p;
        logic          n;
        logic          taken;
        logic          redir;
        logic [31:0]   cpc;
        logic [DW:0]   rem;
        logic [DW-1:0] quo;
        logic [DW-1:0] dvs;
    } t_stg;

    typedef struct packed {
        logic [31:0] res;
        logic        z;
        logic        p;
        logic        n;
        logic        fw;
        logic        taken;
        logic        redir;
        logic [31:0] cpc;
        logic        dz;
    } t_res;

    function automatic t_stg f_step(input t_stg s);
        t_stg        o;
        logic [DW:0] sh;
        logic [DW:0] df;
        o  = s;
        sh = {s.rem[DW-1:0], s.quo[DW-1]};
        df = sh - {1'b0, s.dvs};
        if (!df[DW]) begin
            o.rem = df;
            o.quo = {s.quo[DW-2:0], 1'b1};
        end else begin
            o.rem = sh;
            o.quo = {s.quo[DW-2:0], 1'b0};
        end
        return o;
    endfunction

    t_stg          r_stg [DW+1];
    logic          r_vld [DW+1];
    t_res          r_out;
    logic          r_out_v;
    t_res          n_out;
    t_stg          n_s0;
    logic          adv;
    logic [DW-1:0] a, b, c, imm, br_d, seq_d, sb;
    logic [31:0]   seq, br, target;
    logic          taken;
    logic [DW-1:0] fres;

    assign adv    = !r_out_v || pop;
    assign o_take = adv;
    assign empty  = !r_out_v;

    always_comb begin
        a      = f_opnd(i_head.a);
        b      = f_opnd(i_head.b);
        c      = f_opnd(i_head.c);
        imm    = f_opnd(i_head.imm);
        seq    = i_head.pc + PC_STEP;
        br     = i_head.pc + i_head.imm;
        seq_d  = f_pcval(seq);
        br_d   = f_pcval(br);
        sb     = {1'b1, {(DW-1){1'b0}}};
        taken  = 1'b0;
        target = seq;
        n_s0   = '0;
        n_s0.fw = i_head.cls.fw;
        n_s0.is_div = i_head.cls.is_div;
        n_s0.z = i_head.z;
        n_s0.p = i_head.p;
        n_s0.n = i_head.n;
        unique case (i_head.op)
            OP_ADD, OP_LDR: n_s0.res = a + b;
            OP_SUB:  n_s0.res = a - b;
            OP_AND:  n_s0.res = a & b;
            OP_OR:   n_s0.res = a | b;
            OP_XOR:  n_s0.res = a ^ b;
            OP_MOVC: n_s0.res = imm;
            OP_ADDL, OP_LOAD: n_s0.res = a + imm;
            OP_SUBL: n_s0.res = a - imm;
            OP_CMP: n_s0.res = ((a ^ sb) == (b ^ sb)) ? '0 :
                               ((a ^ sb) < (b ^ sb)) ? '1 : DW'(1);
            OP_CML: n_s0.res = ((a ^ sb) == (imm ^ sb)) ? '0 :
                               ((a ^ sb) < (imm ^ sb)) ? '1 : DW'(1);
            OP_MUL:  n_s0.res = a * b;
            OP_BZ, OP_BNZ, OP_BP, OP_BN, OP_BNP: begin
                n_s0.res = br_d;
                unique case (i_head.op)
                    OP_BZ:   taken = i_head.z;
                    OP_BNZ:  taken = !i_head.z;
                    OP_BP:   taken = i_head.p;
                    OP_BN:   taken = i_head.n;
                    default: taken = !i_head.p;
                endcase
                target = taken ? br : seq;
            end
            OP_JUMP: begin
                taken    = 1'b1;
                n_s0.res = a + imm;
                target   = i_head.a + i_head.imm;
            end
            OP_JALP: begin
                taken    = 1'b1;
                n_s0.res = seq_d;
                target   = br;
            end
            OP_RET: begin
                taken    = 1'b1;
                n_s0.res = a;
                target   = i_head.a;
            end
            OP_STW:   n_s0.res = b + imm;
            OP_STR:   n_s0.res = b + c;
            default:  n_s0.res = '0;
        endcase
        n_s0.taken = taken;
        n_s0.cpc   = target;
        n_s0.redir = i_head.cls.ctl && (target != i_head.pred);
        n_s0.dz    = i_head.cls.is_div && (b == '0);
        n_s0.qneg  = a[DW-1] ^ b[DW-1];
        n_s0.quo   = a[DW-1] ? (DW'(0) - a) : a;
        n_s0.dvs   = b[DW-1] ? (DW'(0) - b) : b;
        n_s0.rem   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_stg[0] <= n_s0;
            for (int k = 1; k <= DW; k++) begin
                r_stg[k] <= f_step(r_stg[k-1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DW; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= i_avail;
            for (int k = 1; k <= DW; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_comb begin
        fres = r_stg[DW].res;
        if (r_stg[DW].is_div) begin
            fres = r_stg[DW].dz   ? '0 :
                   r_stg[DW].qneg ? (DW'(0) - r_stg[DW].quo) : r_stg[DW].quo;
        end
        n_out.res   = f_out(fres);
        n_out.fw    = r_stg[DW].fw;
        n_out.taken = r_stg[DW].taken;
        n_out.redir = r_stg[DW].redir;
        n_out.cpc   = r_stg[DW].cpc;
        n_out.dz    = r_stg[DW].dz;
        if (r_stg[DW].fw) begin
            n_out.z = (fres == '0);
            n_out.n = fres[DW-1];
            n_out.p = (fres != '0) && !fres[DW-1];
        end else begin
            n_out.z = r_stg[DW].z;
            n_out.p = r_stg[DW].p;
            n_out.n = r_stg[DW].n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_vld[DW];
        end
    end

    assign o_result_value   = r_out.res;
    assign o_out_zero       = r_out.z;
    assign o_out_positive   = r_out.p;
    assign o_out_negative   = r_out.n;
    assign o_flags_written  = r_out.fw;
    assign o_branch_taken   = r_out.taken;
    assign o_redirect       = r_out.redir;
    assign o_correct_pc     = r_out.cpc;
    assign o_divide_by_zero = r_out.dz;

endmodule
